// File: rtl/gpcf_pkg.sv
// shared constants, register codes and types of the peak clip filter
`default_nettype none

package gpcf_pkg;

	// design defaults
	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned PIXEL_BITS_DEF = 16;

	// configuration register layout
	localparam int unsigned CFG_WIDTH_BITS  = 11;
	localparam int unsigned CFG_HEIGHT_BITS = 16;
	localparam int unsigned ROW_BITS        = 16;
	localparam int unsigned APB_ADDR_BITS   = 3;
	localparam int unsigned APB_DATA_BITS   = 32;

	localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;

	// register index codes (byte address / 4)
	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	// item kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// which neighbors take part, plus the end-of-frame mark, for one output pixel
	typedef struct packed {
		logic use_up;
		logic use_down;
		logic use_left;
		logic use_right;
		logic frame_end;
	} nbr_sel_t;

endpackage

`default_nettype wire

// File: rtl/gpcf_if.sv
// item channels of the peak clip filter: input request and output pixel
`default_nettype none

interface gpcf_in_if #(
	parameter int unsigned PIXEL_BITS = gpcf_pkg::PIXEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [PIXEL_BITS-1:0] pixel_value;

	modport source (output valid, output req_type, output pixel_value, input ready);
	modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

interface gpcf_out_if #(
	parameter int unsigned PIXEL_BITS = gpcf_pkg::PIXEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_out;
	logic                  frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/gpcf_cfg.sv
// apb register block: frame width and height, restart on every write
`default_nettype none

module gpcf_cfg (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       psel,
	input  wire                                       penable,
	input  wire                                       pwrite,
	input  wire  [gpcf_pkg::APB_ADDR_BITS-1:0]        paddr,
	input  wire  [gpcf_pkg::APB_DATA_BITS-1:0]        pwdata,
	output logic [gpcf_pkg::APB_DATA_BITS-1:0]        prdata,
	output logic                                      pready,
	output logic [gpcf_pkg::CFG_WIDTH_BITS-1:0]       frame_width,
	output logic [gpcf_pkg::CFG_HEIGHT_BITS-1:0]      frame_height,
	output logic                                      restart
);

	logic       wr_en;
	logic [0:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2:2];
	assign restart = wr_en;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width  <= gpcf_pkg::WIDTH_RESET;
			frame_height <= gpcf_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				gpcf_pkg::REG_FRAME_WIDTH: begin
					frame_width <= pwdata[gpcf_pkg::CFG_WIDTH_BITS-1:0];
				end
				gpcf_pkg::REG_FRAME_HEIGHT: begin
					frame_height <= pwdata[gpcf_pkg::CFG_HEIGHT_BITS-1:0];
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			gpcf_pkg::REG_FRAME_WIDTH: begin
				prdata = gpcf_pkg::APB_DATA_BITS'(frame_width);
			end
			gpcf_pkg::REG_FRAME_HEIGHT: begin
				prdata = gpcf_pkg::APB_DATA_BITS'(frame_height);
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/gpcf_line_mem.sv
// line store: two copies of the pixel history, each with two synchronous read ports
`default_nettype none

module gpcf_line_mem #(
	parameter int unsigned MAX_WIDTH  = gpcf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned PIXEL_BITS = gpcf_pkg::PIXEL_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    we,
	input  wire  [$clog2(2*MAX_WIDTH+2)-1:0]       waddr,
	input  wire  [PIXEL_BITS-1:0]                  wdata,
	input  wire                                    re,
	input  wire  [$clog2(2*MAX_WIDTH+2)-1:0]       ra_center,
	input  wire  [$clog2(2*MAX_WIDTH+2)-1:0]       ra_right,
	input  wire  [$clog2(2*MAX_WIDTH+2)-1:0]       ra_up,
	input  wire  [$clog2(2*MAX_WIDTH+2)-1:0]       ra_down,
	output logic [PIXEL_BITS-1:0]                  rd_center,
	output logic [PIXEL_BITS-1:0]                  rd_right,
	output logic [PIXEL_BITS-1:0]                  rd_up,
	output logic [PIXEL_BITS-1:0]                  rd_down
);

	localparam int unsigned DEPTH = 2 * MAX_WIDTH + 2;

	logic [PIXEL_BITS-1:0] mem_row [DEPTH];
	logic [PIXEL_BITS-1:0] mem_vert [DEPTH];

	// copy for the center row: center and right neighbor
	always_ff @(posedge clk) begin
		if (we) begin
			mem_row[waddr] <= wdata;
		end
		if (re) begin
			rd_center <= mem_row[ra_center];
			rd_right  <= mem_row[ra_right];
		end
	end

	// copy for the rows above and below
	always_ff @(posedge clk) begin
		if (we) begin
			mem_vert[waddr] <= wdata;
		end
		if (re) begin
			rd_up   <= mem_vert[ra_up];
			rd_down <= mem_vert[ra_down];
		end
	end

endmodule

`default_nettype wire

// File: rtl/gpcf_ctrl.sv
// stream control: write and read pointers, pending count, raster position, emit decision
`default_nettype none

module gpcf_ctrl #(
	parameter int unsigned MAX_WIDTH  = gpcf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned PIXEL_BITS = gpcf_pkg::PIXEL_BITS_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      restart,
	input  wire  [gpcf_pkg::CFG_WIDTH_BITS-1:0]      frame_width,
	input  wire  [gpcf_pkg::CFG_HEIGHT_BITS-1:0]     frame_height,
	input  wire                                      fire,
	input  wire                                      req_type,
	input  wire  [PIXEL_BITS-1:0]                    pixel_value,
	output logic                                     issue,
	output gpcf_pkg::nbr_sel_t                       sel,
	output logic                                     we,
	output logic [$clog2(2*MAX_WIDTH+2)-1:0]         waddr,
	output logic [PIXEL_BITS-1:0]                    wdata,
	output logic [$clog2(2*MAX_WIDTH+2)-1:0]         ra_center,
	output logic [$clog2(2*MAX_WIDTH+2)-1:0]         ra_right,
	output logic [$clog2(2*MAX_WIDTH+2)-1:0]         ra_up,
	output logic [$clog2(2*MAX_WIDTH+2)-1:0]         ra_down
);

	localparam int unsigned DEPTH = 2 * MAX_WIDTH + 2;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned PW    = $clog2(MAX_WIDTH + 3);
	localparam int unsigned RW    = gpcf_pkg::ROW_BITS;
	localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);

	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [PW-1:0] pend_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [31:0]   w_ext;
	logic [WW-1:0] w_eff;
	logic [WW-1:0] w_m1;
	logic [RW-1:0] h_m1;
	logic          last_col;
	logic          last_row;
	logic          pend_gt_w;
	logic          emit;
	logic          is_pixel;

	// modular add and subtract over the circular store
	function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_V) begin
			s = s - DEPTH_V;
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] d;
		if (a >= b) begin
			d = {1'b0, a} - {1'b0, b};
		end else begin
			d = {1'b0, a} + DEPTH_V - {1'b0, b};
		end
		return d[AW-1:0];
	endfunction

	// effective frame size: zero width or height means one, width saturates
	assign w_ext = 32'(frame_width);
	always_comb begin
		if (frame_width == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(w_ext);
		end
	end
	assign w_m1 = w_eff - WW'(1);
	assign h_m1 = (frame_height == '0) ? '0 : frame_height - RW'(1);

	// raster position of the oldest pending pixel
	assign last_col  = (WW'(col_q) == w_m1);
	assign last_row  = (row_q == h_m1);
	assign pend_gt_w = (pend_q > PW'(w_eff));
	assign is_pixel  = (req_type == gpcf_pkg::REQ_PIXEL);

	// emit decision: a pixel pushes out the oldest once the window is full,
	// a flush only once the neighbors that pixel needs have arrived
	always_comb begin
		unique case (req_type)
			gpcf_pkg::REQ_PIXEL: begin
				emit = pend_gt_w;
			end
			gpcf_pkg::REQ_FLUSH: begin
				emit = (pend_q != '0) && !(!last_row && !pend_gt_w)
					&& !(!last_col && (pend_q == PW'(1)));
			end
		endcase
	end

	assign issue = fire & emit;

	assign sel.use_up    = (row_q != '0);
	assign sel.use_down  = !last_row;
	assign sel.use_left  = (col_q != '0);
	assign sel.use_right = !last_col;
	assign sel.frame_end = last_row & last_col;

	// store access
	assign we        = fire & is_pixel;
	assign waddr     = wr_q;
	assign wdata     = pixel_value;
	assign ra_center = rd_q;
	assign ra_right  = add_mod(rd_q, AW'(1));
	assign ra_up     = sub_mod(rd_q, AW'(w_eff));
	assign ra_down   = add_mod(rd_q, AW'(w_eff));

	// pointer, count and position update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			pend_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (restart) begin
			wr_q   <= '0;
			rd_q   <= '0;
			pend_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (fire) begin
			if (is_pixel) begin
				wr_q <= add_mod(wr_q, AW'(1));
			end
			pend_q <= pend_q + PW'(is_pixel) - PW'(emit);
			if (emit) begin
				rd_q <= add_mod(rd_q, AW'(1));
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

`ifndef SYNTHESIS
	// never more pending than one row plus one pixel
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(w_eff) + PW'(1))
		else $error("pending count exceeds row plus one");

	// the read pointer trails the write pointer by exactly the pending count
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q == sub_mod(wr_q, AW'(pend_q)))
		else $error("read pointer out of step with pending count");

	// output position stays inside the frame
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) <= w_m1)
		else $error("output column beyond frame width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_m1)
		else $error("output row beyond frame height");
`endif

endmodule

`default_nettype wire

// File: rtl/gpcf_clip.sv
// clip stage: compare center with its neighbors, output register with handshake
`default_nettype none

module gpcf_clip #(
	parameter int unsigned PIXEL_BITS = gpcf_pkg::PIXEL_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      issue,
	input  wire gpcf_pkg::nbr_sel_t  sel,
	input  wire  [PIXEL_BITS-1:0]    rd_center,
	input  wire  [PIXEL_BITS-1:0]    rd_right,
	input  wire  [PIXEL_BITS-1:0]    rd_up,
	input  wire  [PIXEL_BITS-1:0]    rd_down,
	output logic                     take,
	gpcf_out_if.source               pix_out
);

	logic                  valid_s1;
	gpcf_pkg::nbr_sel_t    sel_s1;
	logic [PIXEL_BITS-1:0] left_q;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] pixel_q;
	logic                  frame_end_q;
	logic                  out_free;
	logic                  adv;
	logic                  peak;
	logic                  any_nbr;
	logic [PIXEL_BITS-1:0] best;
	logic [PIXEL_BITS-1:0] result;

	// handshake: stage 1 moves on when the output register is free
	assign out_free = !out_valid_q || pix_out.ready;
	assign adv      = valid_s1 && out_free;
	assign take     = !valid_s1 || out_free;

	// strict peak test and largest neighbor; left is the previous center
	always_comb begin
		peak    = 1'b1;
		best    = '0;
		any_nbr = sel_s1.use_up | sel_s1.use_down | sel_s1.use_left | sel_s1.use_right;
		if (sel_s1.use_up) begin
			if (rd_center <= rd_up) peak = 1'b0;
			if (rd_up > best) best = rd_up;
		end
		if (sel_s1.use_down) begin
			if (rd_center <= rd_down) peak = 1'b0;
			if (rd_down > best) best = rd_down;
		end
		if (sel_s1.use_left) begin
			if (rd_center <= left_q) peak = 1'b0;
			if (left_q > best) best = left_q;
		end
		if (sel_s1.use_right) begin
			if (rd_center <= rd_right) peak = 1'b0;
			if (rd_right > best) best = rd_right;
		end
		result = (any_nbr && peak) ? best : rd_center;
	end

	// stage 1 and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) begin
			sel_s1 <= sel;
		end
		if (adv) begin
			pixel_q     <= result;
			frame_end_q <= sel_s1.frame_end;
			left_q      <= rd_center;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.pixel_out = pixel_q;
	assign pix_out.frame_end = frame_end_q;

endmodule

`default_nettype wire

// File: rtl/grid_peak_clip_filter.sv
// Four-neighbor hot pixel clip on a raster pixel stream. Each pixel strictly
// greater than all of its existing up, down, left and right neighbors is
// replaced by the largest of them; edges use only the neighbors inside the
// frame. One item (pixel or flush tick) is taken every clock cycle while the
// output is not stalled; that rate is set by the line store, two copies of
// 2*MAX_WIDTH+2 entries that each serve two reads per cycle while the incoming
// pixel is written. A result passes the store read registers, then the output
// register. Output runs one row plus one pixel behind input; flush ticks release
// the tail of a frame once the neighbors each pixel needs are in. Writing
// frame_width (byte address 0) or frame_height (byte address 4) restarts the
// stream; write them only while idle. No clearing pass follows reset.
`default_nettype none

module grid_peak_clip_filter #(
	parameter int unsigned MAX_WIDTH  = gpcf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned PIXEL_BITS = gpcf_pkg::PIXEL_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	gpcf_in_if.sink                               pix_in,
	gpcf_out_if.source                            pix_out,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [gpcf_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  wire  [gpcf_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [gpcf_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready
);

	localparam int unsigned AW = $clog2(2 * MAX_WIDTH + 2);

	logic [gpcf_pkg::CFG_WIDTH_BITS-1:0]  frame_width;
	logic [gpcf_pkg::CFG_HEIGHT_BITS-1:0] frame_height;
	logic                                 restart;
	logic                                 fire;
	logic                                 take;
	logic                                 issue;
	gpcf_pkg::nbr_sel_t                   sel;
	logic                                 we;
	logic [AW-1:0]                        waddr;
	logic [PIXEL_BITS-1:0]                wdata;
	logic [AW-1:0]                        ra_center;
	logic [AW-1:0]                        ra_right;
	logic [AW-1:0]                        ra_up;
	logic [AW-1:0]                        ra_down;
	logic [PIXEL_BITS-1:0]                rd_center;
	logic [PIXEL_BITS-1:0]                rd_right;
	logic [PIXEL_BITS-1:0]                rd_up;
	logic [PIXEL_BITS-1:0]                rd_down;

	// input handshake
	assign pix_in.ready = take;
	assign fire         = pix_in.valid & take;

	gpcf_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.restart      (restart)
	);

	gpcf_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.fire         (fire),
		.req_type     (pix_in.req_type),
		.pixel_value  (pix_in.pixel_value),
		.issue        (issue),
		.sel          (sel),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.ra_center    (ra_center),
		.ra_right     (ra_right),
		.ra_up        (ra_up),
		.ra_down      (ra_down)
	);

	gpcf_line_mem #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_mem (
		.clk       (clk),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (issue),
		.ra_center (ra_center),
		.ra_right  (ra_right),
		.ra_up     (ra_up),
		.ra_down   (ra_down),
		.rd_center (rd_center),
		.rd_right  (rd_right),
		.rd_up     (rd_up),
		.rd_down   (rd_down)
	);

	gpcf_clip #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.sel       (sel),
		.rd_center (rd_center),
		.rd_right  (rd_right),
		.rd_up     (rd_up),
		.rd_down   (rd_down),
		.take      (take),
		.pix_out   (pix_out)
	);

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench of the peak clip filter: directed and random pixel streams
`timescale 1ns / 1ps

module tb;

	localparam int unsigned LINE_SLOTS    = 2 * gpcf_pkg::MAX_WIDTH_DEF + 2;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned NOISE_PCT     = 10;

	typedef struct packed {
		logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] pixel;
		logic                                last;
	} clip_pixel_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [gpcf_pkg::APB_ADDR_BITS-1:0] paddr = '0;
	logic [gpcf_pkg::APB_DATA_BITS-1:0] pwdata = '0;
	logic [gpcf_pkg::APB_DATA_BITS-1:0] prdata;
	logic                               pready;

	gpcf_in_if  pix_in_ch ();
	gpcf_out_if pix_out_ch ();

	grid_peak_clip_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_ch),
		.pix_out (pix_out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state: pixel history, raster position of the next output, registers
	logic [gpcf_pkg::PIXEL_BITS_DEF-1:0]  pix_hist [LINE_SLOTS];
	int unsigned                          hist_wr = 0;
	int unsigned                          backlog = 0;
	int unsigned                          next_col = 0;
	int unsigned                          next_row = 0;
	logic [gpcf_pkg::CFG_WIDTH_BITS-1:0]  width_reg = gpcf_pkg::WIDTH_RESET;
	logic [gpcf_pkg::CFG_HEIGHT_BITS-1:0] height_reg = gpcf_pkg::HEIGHT_RESET;
	clip_pixel_t                          clipped_q [$];

	int unsigned err_count = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	always #2 clk = ~clk;

	function automatic int unsigned row_len();
		if (width_reg == 0) return 1;
		if (width_reg > gpcf_pkg::MAX_WIDTH_DEF) return gpcf_pkg::MAX_WIDTH_DEF;
		return int'(width_reg);
	endfunction

	function automatic int unsigned frame_rows();
		return (height_reg == 0) ? 1 : int'(height_reg);
	endfunction

	// filter the oldest unreleased pixel and queue it as the next expected item
	function automatic void clip_oldest();
		int unsigned                         w;
		int unsigned                         h;
		int unsigned                         slot;
		int unsigned                         nb_slot [4];
		bit                                  has_nb [4];
		bit                                  any_nb;
		bit                                  peak;
		logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] center;
		logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] top;
		clip_pixel_t                         res;
		w = row_len();
		h = frame_rows();
		slot = (hist_wr + LINE_SLOTS - backlog) % LINE_SLOTS;
		center = pix_hist[slot];
		top = '0;
		peak = 1'b1;
		any_nb = 1'b0;
		// up, down, left, right; only neighbors inside the frame count
		has_nb = '{next_row > 0, next_row + 1 < h, next_col > 0, next_col + 1 < w};
		nb_slot = '{(slot + LINE_SLOTS - w) % LINE_SLOTS, (slot + w) % LINE_SLOTS,
			(slot + LINE_SLOTS - 1) % LINE_SLOTS, (slot + 1) % LINE_SLOTS};
		for (int d = 0; d < 4; d++) begin
			if (has_nb[d]) begin
				any_nb = 1'b1;
				if (center <= pix_hist[nb_slot[d]]) peak = 1'b0;
				if (pix_hist[nb_slot[d]] > top) top = pix_hist[nb_slot[d]];
			end
		end
		res.pixel = (any_nb && peak) ? top : center;
		res.last = (next_row + 1 >= h) && (next_col + 1 >= w);
		clipped_q.push_back(res);
		backlog--;
		next_col++;
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
			if (next_row >= h) next_row = 0;
		end
	endfunction

	// update the predictor for one accepted item
	function automatic void predict_item(input logic kind,
			input logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] value);
		int unsigned w;
		int unsigned h;
		w = row_len();
		h = frame_rows();
		if (kind == gpcf_pkg::REQ_PIXEL) begin
			pix_hist[hist_wr] = value;
			hist_wr = (hist_wr + 1) % LINE_SLOTS;
			backlog++;
			if (backlog > w + 1) clip_oldest();
		end else if (backlog > 0 && !(next_row + 1 < h && backlog <= w)
				&& !(next_col + 1 < w && backlog <= 1)) begin
			// a flush tick releases the oldest pixel once its right and lower neighbors are in
			clip_oldest();
		end
	endfunction

	function automatic logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] random_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			// tiny values make ties between neighbors common
			2, 3: return 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one item and wait until it is taken
	task automatic send_item(input logic kind, input logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in_ch.valid <= 1'b1;
		pix_in_ch.req_type <= kind;
		pix_in_ch.pixel_value <= value;
		do @(posedge clk); while (!pix_in_ch.ready);
		predict_item(kind, value);
	endtask

	// whole frames of random pixels, with stray flush ticks mixed in
	task automatic send_stream(input int unsigned n_items, input int unsigned noise_pct);
		int unsigned frame_px;
		int unsigned pos;
		int unsigned sent;
		frame_px = row_len() * frame_rows();
		pos = 0;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < noise_pct) begin
				send_item(gpcf_pkg::REQ_FLUSH, 16'($urandom));
			end else begin
				send_item(gpcf_pkg::REQ_PIXEL, random_pixel());
				pos++;
			end
			sent++;
			// at a frame edge, sometimes drain the tail before the next frame
			if (pos == frame_px) begin
				pos = 0;
				if ($urandom_range(1) == 1) begin
					repeat (row_len() + 2) send_item(gpcf_pkg::REQ_FLUSH, 16'($urandom));
					sent += row_len() + 2;
				end
			end
		end
	endtask

	// wait until every expected item is out and the pipeline is empty
	task automatic settle();
		pix_in_ch.valid <= 1'b0;
		while (clipped_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// read one register back and compare with the value last written
	task automatic check_reg(input logic [0:0] idx);
		logic [gpcf_pkg::APB_DATA_BITS-1:0] want;
		want = (idx == gpcf_pkg::REG_FRAME_WIDTH) ? gpcf_pkg::APB_DATA_BITS'(width_reg)
			: gpcf_pkg::APB_DATA_BITS'(height_reg);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("register %0d: expected %h, actual %h", idx, want, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// register write; the block restarts its stream, and so does the predictor
	task automatic write_reg(input logic [0:0] idx,
			input logic [gpcf_pkg::APB_DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == gpcf_pkg::REG_FRAME_WIDTH) width_reg = value[gpcf_pkg::CFG_WIDTH_BITS-1:0];
		else height_reg = value[gpcf_pkg::CFG_HEIGHT_BITS-1:0];
		hist_wr = 0;
		backlog = 0;
		next_col = 0;
		next_row = 0;
		check_reg(idx);
	endtask

	task automatic reconfigure(input logic [gpcf_pkg::APB_DATA_BITS-1:0] w,
			input logic [gpcf_pkg::APB_DATA_BITS-1:0] h);
		settle();
		write_reg(gpcf_pkg::REG_FRAME_WIDTH, w);
		write_reg(gpcf_pkg::REG_FRAME_HEIGHT, h);
	endtask

	task automatic test_reset_values();
		check_reg(gpcf_pkg::REG_FRAME_WIDTH);
		check_reg(gpcf_pkg::REG_FRAME_HEIGHT);
	endtask

	// 1x1 frames pass through; flush ticks with nothing pending do nothing
	task automatic test_one_pixel_frames();
		reconfigure(1, 1);
		send_item(gpcf_pkg::REQ_PIXEL, 16'hFFFF);
		send_item(gpcf_pkg::REQ_PIXEL, 16'h0000);
		repeat (3) send_item(gpcf_pkg::REQ_FLUSH, 16'hFFFF);
	endtask

	// corner peak, center peak and a tie that is not a peak
	task automatic test_peak_grid();
		logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] grid_px [9] = '{16'h0050, 16'h0020, 16'h0010,
			16'h0020, 16'hFFFF, 16'h0030, 16'h0010, 16'h0040, 16'h0040};
		reconfigure(3, 3);
		foreach (grid_px[i]) send_item(gpcf_pkg::REQ_PIXEL, grid_px[i]);
		repeat (5) send_item(gpcf_pkg::REQ_FLUSH, 16'h0000);
	endtask

	// single-row frame: the last pixel has only a left neighbor
	task automatic test_single_row();
		logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] row_px [5] = '{16'h0001, 16'hFFFF, 16'h0002,
			16'h0002, 16'h0007};
		reconfigure(5, 1);
		foreach (row_px[i]) send_item(gpcf_pkg::REQ_PIXEL, row_px[i]);
		repeat (6) send_item(gpcf_pkg::REQ_FLUSH, 16'h0000);
	endtask

	// single-column frame: only up and down neighbors exist
	task automatic test_single_column();
		logic [gpcf_pkg::PIXEL_BITS_DEF-1:0] col_px [4] = '{16'h0003, 16'h0000, 16'h0008,
			16'hFFFF};
		reconfigure(1, 4);
		foreach (col_px[i]) send_item(gpcf_pkg::REQ_PIXEL, col_px[i]);
		repeat (3) send_item(gpcf_pkg::REQ_FLUSH, 16'h0000);
	endtask

	// small random frame sizes under each idling mix, plus a zero width and zero and maximum heights
	task automatic test_random_streams();
		int unsigned w;
		int unsigned h;
		for (int phase = 0; phase < 8; phase++) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 6);
			if (phase == 2) w = 0;
			if (phase == 5) h = 0;
			if (phase == 6) h = 65535;
			reconfigure(w, h);
			case (phase % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 66;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 66;
				end
				default: begin
					src_idle_pct = 8;
					sink_stall_pct = 8;
				end
			endcase
			send_stream(85, NOISE_PCT);
		end
	endtask

	// long output hold while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		reconfigure(4, 3);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_request = HOLD_CYCLES;
		send_stream(100, 0);
	endtask

	// width above the maximum saturates; one long row released by flush ticks
	task automatic test_full_width();
		reconfigure(32'h7FF, 1);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (100) begin
			send_item(gpcf_pkg::REQ_PIXEL, random_pixel());
			send_item(gpcf_pkg::REQ_FLUSH, 16'h0000);
		end
	endtask

	// output side: random stalls, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			pix_out_ch.ready <= 1'b0;
		end else begin
			pix_out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// compare every item taken from the output with the oldest expectation
	always @(posedge clk) begin
		clip_pixel_t want;
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
			if (clipped_q.size() == 0) begin
				$error("unexpected item: pixel_out %h, frame_end %b",
					pix_out_ch.pixel_out, pix_out_ch.frame_end);
				err_count++;
			end else begin
				want = clipped_q.pop_front();
				if (pix_out_ch.pixel_out !== want.pixel) begin
					$error("pixel_out: expected %h, actual %h", want.pixel, pix_out_ch.pixel_out);
					err_count++;
				end
				if (pix_out_ch.frame_end !== want.last) begin
					$error("frame_end: expected %b, actual %b", want.last, pix_out_ch.frame_end);
					err_count++;
				end
			end
		end
	end

	// watchdog: too many cycles in a row with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (pix_in_ch.valid && pix_in_ch.ready)
				|| (pix_out_ch.valid && pix_out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		pix_in_ch.valid = 1'b0;
		pix_in_ch.req_type = gpcf_pkg::REQ_PIXEL;
		pix_in_ch.pixel_value = '0;
		pix_out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_one_pixel_frames();
		test_peak_grid();
		test_single_row();
		test_single_column();
		test_random_streams();
		test_backpressure();
		test_full_width();
		settle();
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/gpcf_pkg.sv
rtl/gpcf_if.sv
rtl/gpcf_cfg.sv
rtl/gpcf_line_mem.sv
rtl/gpcf_ctrl.sv
rtl/gpcf_clip.sv
rtl/grid_peak_clip_filter.sv
tb/tb.sv
